// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int unsigned IDLE_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0] IDLE_TICKS_RST    = 16'd1500;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST    = 8'd64;
    localparam logic [BYTE_W-1:0] FRAME_ADDRESS_RST = 8'd200;
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST    = 8'd22;

    localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ADDRESS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE    = 2'd3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic EV_PAYLOAD = 1'b0;
    localparam logic EV_LEN_ERR = 1'b1;

    typedef struct packed {
        logic [IDLE_W-1:0] idle_ticks;
        logic [BYTE_W-1:0] max_length;
        logic [BYTE_W-1:0] frame_address;
        logic [BYTE_W-1:0] frame_type;
    } t_cfg;

    typedef struct packed {
        logic              event_res;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_byte;
    } t_result;

endpackage

// ===== rtl/sfr_in_if.sv =====
interface sfr_in_if import sfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// ===== rtl/sfr_out_if.sv =====
interface sfr_out_if import sfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              event_res;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;

    modport source (output valid, output event_res, output payload_byte, output last_byte,
                    input ready);
    modport sink (input valid, input event_res, input payload_byte, input last_byte,
                  output ready);
endinterface

// ===== rtl/sfr_parser.sv =====
module sfr_parser import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_SYNC  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;

    logic [1:0]        r_phase,        n_phase;
    logic [IDLE_W-1:0] r_idle_count,   n_idle_count;
    logic [BYTE_W-1:0] r_byte_count,   n_byte_count;
    logic [BYTE_W-1:0] r_seen_address, n_seen_address;
    logic [BYTE_W-1:0] r_frame_length, n_frame_length;
    logic              r_frame_match,  n_frame_match;

    logic [IDLE_W-1:0] w_idle_inc;
    logic [BYTE_W:0]   w_count_inc;
    logic              w_last;

    assign w_idle_inc  = (r_idle_count == {IDLE_W{1'b1}}) ? r_idle_count
                                                          : r_idle_count + 1'b1;
    assign w_count_inc = {1'b0, r_byte_count} + 1'b1;
    assign w_last      = w_count_inc >= {1'b0, r_frame_length};

    always_comb begin
        n_phase        = r_phase;
        n_idle_count   = r_idle_count;
        n_byte_count   = r_byte_count;
        n_seen_address = r_seen_address;
        n_frame_length = r_frame_length;
        n_frame_match  = r_frame_match;
        o_res_valid    = 1'b0;
        o_res          = '{event_res: EV_PAYLOAD, payload_byte: i_data_byte, last_byte: 1'b0};

        if (i_step) begin
            case (r_phase)
                PH_SYNC: begin
                    if (i_opcode == OP_BYTE) begin
                        if (r_byte_count == '0) begin
                            n_seen_address = i_data_byte;
                            n_byte_count   = 8'd1;
                        end else if (i_data_byte >= MIN_LENGTH
                                     && i_data_byte <= i_cfg.max_length) begin
                            n_frame_length = i_data_byte;
                            n_phase        = PH_FRAME;
                            n_byte_count   = '0;
                        end else begin
                            n_phase      = PH_HUNT;
                            n_idle_count = '0;
                            n_byte_count = '0;
                            o_res_valid  = 1'b1;
                            o_res        = '{event_res: EV_LEN_ERR, payload_byte: '0,
                                             last_byte: 1'b0};
                        end
                    end
                end
                PH_FRAME: begin
                    if (i_opcode == OP_BYTE) begin
                        if (r_byte_count == '0) begin
                            n_frame_match = (r_seen_address == i_cfg.frame_address)
                                            && (i_data_byte == i_cfg.frame_type);
                            n_byte_count  = 8'd1;
                        end else begin
                            if (w_last) begin
                                n_phase      = PH_HUNT;
                                n_idle_count = '0;
                                n_byte_count = '0;
                            end else begin
                                n_byte_count = w_count_inc[BYTE_W-1:0];
                            end
                            o_res_valid = r_frame_match;
                            o_res       = '{event_res: EV_PAYLOAD, payload_byte: i_data_byte,
                                            last_byte: w_last};
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_opcode == OP_TICK) begin
                        n_idle_count = w_idle_inc;
                        if (w_idle_inc >= i_cfg.idle_ticks) begin
                            n_phase      = PH_SYNC;
                            n_byte_count = '0;
                        end
                    end else begin
                        n_idle_count = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_idle_count   <= '0;
            r_byte_count   <= '0;
            r_seen_address <= '0;
            r_frame_length <= '0;
            r_frame_match  <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_idle_count   <= n_idle_count;
            r_byte_count   <= n_byte_count;
            r_seen_address <= n_seen_address;
            r_frame_length <= n_frame_length;
            r_frame_match  <= n_frame_match;
        end
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("parser phase left the legal codes");

    a_sync_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SYNC |-> r_byte_count <= 8'd1)
        else $error("byte count runs past the length byte while synced");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME |-> r_byte_count < r_frame_length && r_frame_length >= MIN_LENGTH)
        else $error("frame byte count overran the frame length");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.event_res == EV_LEN_ERR
        |-> o_res.payload_byte == '0 && !o_res.last_byte && n_phase == PH_HUNT)
        else $error("length error result malformed");

    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_byte |=> r_phase == PH_HUNT && r_idle_count == '0)
        else $error("block did not return to hunting after the last frame byte");

endmodule

// ===== rtl/serial_frame_receiver_core.sv =====
// A taken input beat is registered, parsed, and any result registered at the output.
// Throughput: one input beat per cycle, set by the single parse stage between the input
// and output registers; a stalled output holds the pipeline without losing beats.
// Reset: synchronous, active low; clears the handshake state and the parser to hunting
// and loads the configuration registers with their default values.
module serial_frame_receiver_core import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_in_if.sink                i_in_ch,
    sfr_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic              r_in_opcode;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_advance;
    logic              w_step;
    logic              w_res_valid;
    t_result           w_res;

    assign w_advance     = !r_out_valid || o_out_ch.ready;
    assign w_step        = r_in_valid && w_advance;
    assign i_in_ch.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_ticks    <= IDLE_TICKS_RST;
            r_cfg.max_length    <= MAX_LENGTH_RST;
            r_cfg.frame_address <= FRAME_ADDRESS_RST;
            r_cfg.frame_type    <= FRAME_TYPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDLE_TICKS:    r_cfg.idle_ticks    <= i_cfg_data;
                CFG_MAX_LENGTH:    r_cfg.max_length    <= i_cfg_data[BYTE_W-1:0];
                CFG_FRAME_ADDRESS: r_cfg.frame_address <= i_cfg_data[BYTE_W-1:0];
                CFG_FRAME_TYPE:    r_cfg.frame_type    <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_opcode <= i_in_ch.opcode;
            r_in_data   <= i_in_ch.data_byte;
        end
    end

    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_opcode    (r_in_opcode),
        .i_data_byte (r_in_data),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.event_res    = r_out.event_res;
    assign o_out_ch.payload_byte = r_out.payload_byte;
    assign o_out_ch.last_byte    = r_out.last_byte;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out_ch.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result beat changed while stalled");

    a_no_step_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out_ch.ready |-> !w_step)
        else $error("parser advanced while the output was blocked");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_data)
        && $stable(r_in_opcode))
        else $error("buffered input beat lost during stall");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNTING  = 2'd0,
        PH_SYNCED   = 2'd1,
        PH_IN_FRAME = 2'd2
    } rx_phase_e;

    class frame_scoreboard;
        logic [IDLE_W-1:0] idle_ticks;
        logic [BYTE_W-1:0] max_length;
        logic [BYTE_W-1:0] frame_address;
        logic [BYTE_W-1:0] frame_type;

        rx_phase_e         phase;
        logic [IDLE_W-1:0] idle_count;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] seen_address;
        logic [BYTE_W-1:0] frame_length;
        logic              frame_match;

        t_result expected_q[$];
        int      errors;

        function void clear();
            idle_ticks    = IDLE_TICKS_RST;
            max_length    = MAX_LENGTH_RST;
            frame_address = FRAME_ADDRESS_RST;
            frame_type    = FRAME_TYPE_RST;
            phase         = PH_HUNTING;
            idle_count    = '0;
            byte_count    = '0;
            seen_address  = '0;
            frame_length  = '0;
            frame_match   = 1'b0;
            expected_q.delete();
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_IDLE_TICKS:    idle_ticks    = value[IDLE_W-1:0];
                CFG_MAX_LENGTH:    max_length    = value[BYTE_W-1:0];
                CFG_FRAME_ADDRESS: frame_address = value[BYTE_W-1:0];
                CFG_FRAME_TYPE:    frame_type    = value[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void back_to_hunting();
            phase      = PH_HUNTING;
            idle_count = '0;
            byte_count = '0;
        endfunction

        // Works out what one accepted input beat produces and queues it.
        function void note_beat(logic op, logic [BYTE_W-1:0] b);
            t_result res;
            logic    is_last;
            if (op == OP_TICK) begin
                if (phase == PH_HUNTING) begin
                    if (idle_count != {IDLE_W{1'b1}}) idle_count = idle_count + 1'b1;
                    if (idle_count >= idle_ticks) begin
                        phase      = PH_SYNCED;
                        byte_count = '0;
                    end
                end
                return;
            end
            case (phase)
                PH_SYNCED: begin
                    if (byte_count == 0) begin
                        seen_address = b;
                        byte_count   = 8'd1;
                    end else if (b >= MIN_LENGTH && b <= max_length) begin
                        frame_length = b;
                        phase        = PH_IN_FRAME;
                        byte_count   = '0;
                    end else begin
                        back_to_hunting();
                        res.event_res    = EV_LEN_ERR;
                        res.payload_byte = '0;
                        res.last_byte    = 1'b0;
                        expected_q.push_back(res);
                    end
                end
                PH_IN_FRAME: begin
                    if (byte_count == 0) begin
                        frame_match = (seen_address == frame_address) && (b == frame_type);
                        byte_count  = 8'd1;
                    end else begin
                        is_last = ({1'b0, byte_count} + 9'd1) >= {1'b0, frame_length};
                        if (is_last) back_to_hunting();
                        else byte_count = byte_count + 1'b1;
                        if (frame_match) begin
                            res.event_res    = EV_PAYLOAD;
                            res.payload_byte = b;
                            res.last_byte    = is_last;
                            expected_q.push_back(res);
                        end
                    end
                end
                default: idle_count = '0;
            endcase
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result event=%0d byte=%02h last=%0d",
                                 got.event_res, got.payload_byte, got.last_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res)
                report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
            if (got.payload_byte !== want.payload_byte)
                report($sformatf("payload_byte got %02h want %02h",
                                 got.payload_byte, want.payload_byte));
            if (got.last_byte !== want.last_byte)
                report($sformatf("last_byte got %0d want %0d", got.last_byte, want.last_byte));
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    localparam int STALL_LIMIT = 2000;

    logic                  clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    frame_scoreboard sb = new();

    int send_idle_pct = 22;
    int recv_idle_pct = 69;
    int beats_sent    = 0;
    int stall_cycles  = 0;

    int cur_idle;
    int cur_max;
    int cur_addr;
    int cur_type;

    serial_frame_receiver_core DUT (
        .i_clk       (clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                sb.note_beat(in_ch.opcode, in_ch.data_byte);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.event_res    = out_ch.event_res;
                got.payload_byte = out_ch.payload_byte;
                got.last_byte    = out_ch.last_byte;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic send_beat(logic op, logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= b;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_beat(OP_TICK, BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_byte(int b);
        send_beat(OP_BYTE, BYTE_W'(b));
    endtask

    // Address, length, then count bytes of the frame body starting with the type.
    task automatic send_frame(int addr, int len, int typ, int count);
        send_byte(addr);
        send_byte(len);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(19) == 0) send_ticks(1);
            send_byte(k == 0 ? typ : $urandom_range(255));
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_regs(int idle, int maxlen, int addr, int typ);
        logic [CFG_IDX_W-1:0] idx_list[4];
        int                   vals[4];
        idx_list = '{CFG_IDLE_TICKS, CFG_MAX_LENGTH, CFG_FRAME_ADDRESS, CFG_FRAME_TYPE};
        vals     = '{idle, maxlen, addr, typ};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= CFG_DATA_W'(vals[k]);
            sb.set_reg(idx_list[k], CFG_DATA_W'(vals[k]));
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        cur_idle = idle;
        cur_max  = maxlen;
        cur_addr = addr;
        cur_type = typ;
        @(negedge clk);
    endtask

    task automatic send_random_sequence();
        int r;
        int len;
        int count;
        int len_cap;
        int addr;
        int typ;
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4))
                send_beat(1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) == 0) begin
            send_ticks($urandom_range(0, cur_idle));
            send_byte($urandom_range(255));
        end
        send_ticks(cur_idle + $urandom_range(0, 2));
        addr    = ($urandom_range(3) != 0) ? cur_addr : $urandom_range(255);
        typ     = ($urandom_range(3) != 0) ? cur_type : $urandom_range(255);
        len_cap = (cur_max > 24) ? 24 : cur_max;
        r = $urandom_range(99);
        if (r < 80) len = $urandom_range(3, len_cap);
        else if (r < 90) len = $urandom_range(0, 2);
        else len = $urandom_range(255);
        count = (len >= 3 && len <= cur_max) ? len : 0;
        if (count > 0 && $urandom_range(19) == 0) count = $urandom_range(0, count - 1);
        send_frame(addr, len, typ, count);
    endtask

    task automatic run_random_block(int n_beats);
        int start;
        int maxlen;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) maxlen = 3;
        else if (pick == 1) maxlen = 255;
        else maxlen = $urandom_range(4, 24);
        program_regs($urandom_range(1, 6), maxlen, $urandom_range(255), $urandom_range(255));
        start = beats_sent;
        while (beats_sent - start < n_beats) send_random_sequence();
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_BYTE;
        in_ch.data_byte = '0;
        sb.clear();
        cur_idle = IDLE_TICKS_RST;
        cur_max  = MAX_LENGTH_RST;
        cur_addr = FRAME_ADDRESS_RST;
        cur_type = FRAME_TYPE_RST;
        repeat (5) @(negedge clk);
        i_rst_n <= 1'b1;
        @(negedge clk);

        send_ticks(20);
        send_frame(FRAME_ADDRESS_RST, 3, FRAME_TYPE_RST, 3);
        wait_drained();

        program_regs(2, 255, 0, 255);
        send_ticks(1);
        send_byte(8'hAA);
        send_ticks(1);
        send_byte(8'h55);
        send_ticks(2);
        send_frame(0, 2, 0, 0);
        send_ticks(4);
        send_frame(0, 0, 0, 0);
        send_ticks(2);
        send_frame(0, 255, 255, 255);
        send_ticks(2);
        send_byte(0);
        send_byte(5);
        send_ticks(3);
        send_byte(255);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ticks(2);
        send_frame(1, 4, 255, 4);
        send_ticks(2);
        send_frame(0, 4, 254, 4);
        wait_drained();

        program_regs(65535, 3, 255, 0);
        send_ticks(8);
        send_frame(255, 3, 0, 3);
        wait_drained();

        program_regs(0, 2, 7, 9);
        send_ticks(1);
        send_frame(7, 3, 9, 0);
        send_ticks(1);
        send_frame(7, 2, 9, 0);
        wait_drained();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 22; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_random_block(40);
            run_random_block(40);
        end

        wait_drained();
        sb.close_out();
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
